FILE: rtl/core/fthp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fthp_pkg
// Types and constants shared by the five-tuple header parser modules.
// ----------------------------------------------------------------------------
package fthp_pkg;

  // Header lengths and positions, counted from zero within each header.
  localparam logic [4:0] ETH_TYPE_HI   = 5'd12;
  localparam logic [4:0] ETH_TYPE_LO   = 5'd13;
  localparam logic [4:0] VLAN_TYPE_HI  = 5'd2;
  localparam logic [4:0] VLAN_TYPE_LO  = 5'd3;
  localparam logic [4:0] IP_PROTO_POS  = 5'd9;
  localparam logic [4:0] IP_SRC_FIRST  = 5'd12;
  localparam logic [4:0] IP_SRC_LAST   = 5'd15;
  localparam logic [4:0] IP_DST_FIRST  = 5'd16;
  localparam logic [4:0] IP_DST_LAST   = 5'd19;
  localparam logic [4:0] PORT_SRC_LAST = 5'd1;
  localparam logic [4:0] PORT_LAST     = 5'd3;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Result status codes.
  localparam logic [1:0] ST_FULL  = 2'd0;
  localparam logic [1:0] ST_OTHER = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef enum logic [2:0] {
    PH_ETH        = 3'd0,
    PH_VLAN       = 3'd1,
    PH_IPV4       = 3'd2,
    PH_PORTS      = 3'd3,
    PH_DONE_FULL  = 3'd4,
    PH_DONE_OTHER = 3'd5,
    PH_DONE_UNSUP = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [1:0]  status;
  } out_item_t;

  // Handoff from the parser to the result stage.
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_push_t;

endpackage

FILE: rtl/core/five_tuple_header_parser_core.sv
`timescale 1ns / 1ps
// A finished item is registered in the result stage when its packet's last byte is taken.
// Throughput: one byte per cycle while in_stall is low; the per-byte parse is one compare and shift step.
// The input stalls only while the skid entry of the result stage is occupied.
// Reset (rst_n low, synchronous) returns the parser to the Ethernet header
// phase with all captured fields zero and empties the result stage.
// ----------------------------------------------------------------------------
// five_tuple_header_parser_core
// Byte-serial Ethernet/VLAN/IPv4/TCP-UDP parser that reports one 5-tuple item
// with a status for each packet.
// ----------------------------------------------------------------------------
module five_tuple_header_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fthp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fthp_pkg::out_item_t out_item
);

  // The parser state is updated on every accepted byte. On a byte flagged as
  // last, the parser presents the finished item and clears itself in the
  // same edge, so the first byte of the next packet may follow directly.
  fthp_pkg::res_push_t res;
  logic                skid_full;
  logic                take;

  // A byte is taken whenever the result stage has room for a possible item.
  // The stage holds two items, so a stalled output still lets one more
  // packet finish before the input is held.
  assign in_stall = skid_full;
  assign take     = in_valid && !in_stall;

  fthp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_item (in_item),
    .res     (res)
  );

  // Result register plus one skid entry; out_valid comes straight from a
  // register and never looks at out_stall.
  fthp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .full      (skid_full)
  );

endmodule

FILE: rtl/core/fthp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fthp_parser
// Per-byte header walker that captures the 5-tuple and forms the result.
// ----------------------------------------------------------------------------
module fthp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  fthp_pkg::in_item_t in_item,
  output fthp_pkg::res_push_t res
);

  fthp_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  type_hi_r, type_hi_nxt;
  logic [31:0] src_ip_r, src_ip_nxt;
  logic [31:0] dst_ip_r, dst_ip_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [7:0]  b;
  logic [1:0]  status;

  assign b = in_item.pkt_byte;

  // Next phase, byte position and ethertype high byte.
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r + 5'd1;
    type_hi_nxt = type_hi_r;
    unique case (phase_r)
      fthp_pkg::PH_ETH: begin
        if (pos_r == fthp_pkg::ETH_TYPE_HI) type_hi_nxt = b;
        if (pos_r == fthp_pkg::ETH_TYPE_LO) begin
          pos_nxt = 5'd0;
          if ({type_hi_r, b} == fthp_pkg::ETYPE_IPV4) begin
            phase_nxt = fthp_pkg::PH_IPV4;
          end else if ({type_hi_r, b} == fthp_pkg::ETYPE_VLAN) begin
            phase_nxt = fthp_pkg::PH_VLAN;
          end else begin
            phase_nxt = fthp_pkg::PH_DONE_UNSUP;
          end
        end
      end
      fthp_pkg::PH_VLAN: begin
        if (pos_r == fthp_pkg::VLAN_TYPE_HI) type_hi_nxt = b;
        if (pos_r == fthp_pkg::VLAN_TYPE_LO) begin
          pos_nxt   = 5'd0;
          phase_nxt = ({type_hi_r, b} == fthp_pkg::ETYPE_IPV4) ?
                      fthp_pkg::PH_IPV4 : fthp_pkg::PH_DONE_UNSUP;
        end
      end
      fthp_pkg::PH_IPV4: begin
        if (pos_r == fthp_pkg::IP_DST_LAST) begin
          pos_nxt   = 5'd0;
          phase_nxt = (proto_r == fthp_pkg::PROTO_TCP || proto_r == fthp_pkg::PROTO_UDP) ?
                      fthp_pkg::PH_PORTS : fthp_pkg::PH_DONE_OTHER;
        end
      end
      fthp_pkg::PH_PORTS: begin
        if (pos_r == fthp_pkg::PORT_LAST) begin
          pos_nxt   = 5'd0;
          phase_nxt = fthp_pkg::PH_DONE_FULL;
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // Field capture for the current phase.
  always_comb begin
    src_ip_nxt = src_ip_r;
    dst_ip_nxt = dst_ip_r;
    proto_nxt  = proto_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;
    unique case (phase_r)
      fthp_pkg::PH_IPV4: begin
        if (pos_r == fthp_pkg::IP_PROTO_POS) begin
          proto_nxt = b;
        end else if (pos_r >= fthp_pkg::IP_SRC_FIRST && pos_r <= fthp_pkg::IP_SRC_LAST) begin
          src_ip_nxt = {src_ip_r[23:0], b};
        end else if (pos_r >= fthp_pkg::IP_DST_FIRST && pos_r <= fthp_pkg::IP_DST_LAST) begin
          dst_ip_nxt = {dst_ip_r[23:0], b};
        end
      end
      fthp_pkg::PH_PORTS: begin
        if (pos_r <= fthp_pkg::PORT_SRC_LAST) begin
          sport_nxt = {sport_r[7:0], b};
        end else begin
          dport_nxt = {dport_r[7:0], b};
        end
      end
      default: begin
      end
    endcase
  end

  // Status follows the phase reached after this byte.
  always_comb begin
    unique case (phase_nxt)
      fthp_pkg::PH_DONE_FULL:  status = fthp_pkg::ST_FULL;
      fthp_pkg::PH_DONE_OTHER: status = fthp_pkg::ST_OTHER;
      fthp_pkg::PH_DONE_UNSUP: status = fthp_pkg::ST_UNSUP;
      fthp_pkg::PH_ETH, fthp_pkg::PH_VLAN,
      fthp_pkg::PH_IPV4, fthp_pkg::PH_PORTS: status = fthp_pkg::ST_TRUNC;
      default:                 status = fthp_pkg::ST_UNSUP;
    endcase
  end

  always_comb begin
    res.push        = take && in_item.last_byte;
    res.item.status = status;
    if (status == fthp_pkg::ST_TRUNC) begin
      res.item.src_ip   = '0;
      res.item.dst_ip   = '0;
      res.item.sport    = '0;
      res.item.dport    = '0;
      res.item.protocol = '0;
    end else begin
      res.item.src_ip   = src_ip_nxt;
      res.item.dst_ip   = dst_ip_nxt;
      res.item.sport    = sport_nxt;
      res.item.dport    = dport_nxt;
      res.item.protocol = proto_nxt;
    end
  end

  // The last byte of a packet rearms everything for the next one.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_item.last_byte)) begin
      phase_r   <= fthp_pkg::PH_ETH;
      pos_r     <= '0;
      type_hi_r <= '0;
      src_ip_r  <= '0;
      dst_ip_r  <= '0;
      proto_r   <= '0;
      sport_r   <= '0;
      dport_r   <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      type_hi_r <= type_hi_nxt;
      src_ip_r  <= src_ip_nxt;
      dst_ip_r  <= dst_ip_nxt;
      proto_r   <= proto_nxt;
      sport_r   <= sport_nxt;
      dport_r   <= dport_nxt;
    end
  end

endmodule

FILE: rtl/core/fthp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fthp_out_stage
// Result register with a skid entry so the input side keeps flowing.
// ----------------------------------------------------------------------------
module fthp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  fthp_pkg::res_push_t res,
  input  logic                out_stall,
  output logic                out_valid,
  output fthp_pkg::out_item_t out_item,
  output logic                full
);

  logic                valid_r, valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  fthp_pkg::out_item_t main_r, skid_r;
  logic                pop;
  logic                load_main, load_skid, move_skid;

  assign pop = valid_r && !out_stall;

  always_comb begin
    valid_nxt      = valid_r;
    skid_valid_nxt = skid_valid_r;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    move_skid      = 1'b0;
    if (skid_valid_r) begin
      if (pop) begin
        move_skid      = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (res.push) begin
      if (!valid_r || pop) begin
        load_main = 1'b1;
        valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) main_r <= res.item;
    else if (move_skid) main_r <= skid_r;
    if (load_skid) skid_r <= res.item;
  end

  assign out_valid = valid_r;
  assign out_item  = main_r;
  assign full      = skid_valid_r;

endmodule

FILE: rtl/core/fthp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fthp_checker
// Port-level checks for the five-tuple header parser core.
// ----------------------------------------------------------------------------
module fthp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input fthp_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == fthp_pkg::ST_TRUNC |->
      out_item.src_ip == '0 && out_item.dst_ip == '0 && out_item.protocol == '0 &&
      out_item.sport == '0 && out_item.dport == '0)
    else $error("truncated item carries nonzero fields");

  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == fthp_pkg::ST_UNSUP |->
      out_item.src_ip == '0 && out_item.dst_ip == '0 && out_item.protocol == '0 &&
      out_item.sport == '0 && out_item.dport == '0)
    else $error("unsupported item carries nonzero fields");

  a_other_ports: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == fthp_pkg::ST_OTHER |->
      out_item.sport == '0 && out_item.dport == '0 &&
      out_item.protocol != fthp_pkg::PROTO_TCP && out_item.protocol != fthp_pkg::PROTO_UDP)
    else $error("other-protocol item is inconsistent");

  a_full_proto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == fthp_pkg::ST_FULL |->
      out_item.protocol == fthp_pkg::PROTO_TCP || out_item.protocol == fthp_pkg::PROTO_UDP)
    else $error("full tuple without TCP or UDP protocol");

endmodule

bind five_tuple_header_parser_core fthp_checker u_fthp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the five-tuple header parser. Frames are sent one
// byte per item. A local parser model predicts one 5-tuple per frame, and every
// result the block returns is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fthp_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  fthp_pkg::out_item_t out_item;

  five_tuple_header_parser_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model state. It mirrors what the block has to remember between
  // bytes: the header being walked, the position inside it, the first byte of
  // an ethertype, and the tuple fields captured so far.
  // ---------------------------------------------------------------------------
  fthp_pkg::phase_t    parse_phase;
  logic [4:0]          hdr_pos;
  logic [7:0]          etype_hi;
  fthp_pkg::out_item_t held_tuple;

  // Tuples predicted for frames whose last byte has been accepted, oldest first.
  fthp_pkg::out_item_t expected_tuples[$];

  // Bytes of the frame being sent next.
  logic [7:0]  frame_bytes[$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;

  // Pacing controls. When a steady flag is set, that side never idles, which
  // gives stretches of back-to-back traffic. A nonzero hold request makes the
  // receiver stall for that many cycles before it takes its next result.
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;
  int unsigned rx_hold_cycles = 0;

  function automatic void clear_parser();
    parse_phase = fthp_pkg::PH_ETH;
    hdr_pos     = '0;
    etype_hi    = '0;
    held_tuple  = '0;
  endfunction

  // Advances the parser model by one byte. On the last byte of a frame it
  // queues the predicted tuple and rearms for the next frame.
  function automatic void parse_byte(logic [7:0] b, logic lst);
    logic [15:0]         etype;
    logic                step_on;
    fthp_pkg::out_item_t tuple;
    etype   = {etype_hi, b};
    step_on = 1'b1;
    case (parse_phase)
      fthp_pkg::PH_ETH: begin
        if (hdr_pos == fthp_pkg::ETH_TYPE_HI) etype_hi = b;
        if (hdr_pos == fthp_pkg::ETH_TYPE_LO) begin
          step_on = 1'b0;
          hdr_pos = '0;
          if (etype == fthp_pkg::ETYPE_IPV4) parse_phase = fthp_pkg::PH_IPV4;
          else if (etype == fthp_pkg::ETYPE_VLAN) parse_phase = fthp_pkg::PH_VLAN;
          else parse_phase = fthp_pkg::PH_DONE_UNSUP;
        end
      end
      fthp_pkg::PH_VLAN: begin
        if (hdr_pos == fthp_pkg::VLAN_TYPE_HI) etype_hi = b;
        if (hdr_pos == fthp_pkg::VLAN_TYPE_LO) begin
          // Only one tag is supported: anything but IPv4 inside it ends the parse.
          step_on     = 1'b0;
          hdr_pos     = '0;
          parse_phase = (etype == fthp_pkg::ETYPE_IPV4) ?
                        fthp_pkg::PH_IPV4 : fthp_pkg::PH_DONE_UNSUP;
        end
      end
      fthp_pkg::PH_IPV4: begin
        if (hdr_pos == fthp_pkg::IP_PROTO_POS) begin
          held_tuple.protocol = b;
        end else if (hdr_pos >= fthp_pkg::IP_SRC_FIRST &&
                     hdr_pos <= fthp_pkg::IP_SRC_LAST) begin
          held_tuple.src_ip = {held_tuple.src_ip[23:0], b};
        end else if (hdr_pos >= fthp_pkg::IP_DST_FIRST &&
                     hdr_pos <= fthp_pkg::IP_DST_LAST) begin
          held_tuple.dst_ip = {held_tuple.dst_ip[23:0], b};
        end
        if (hdr_pos == fthp_pkg::IP_DST_LAST) begin
          step_on     = 1'b0;
          hdr_pos     = '0;
          parse_phase = (held_tuple.protocol == fthp_pkg::PROTO_TCP ||
                         held_tuple.protocol == fthp_pkg::PROTO_UDP) ?
                        fthp_pkg::PH_PORTS : fthp_pkg::PH_DONE_OTHER;
        end
      end
      fthp_pkg::PH_PORTS: begin
        if (hdr_pos <= fthp_pkg::PORT_SRC_LAST) begin
          held_tuple.sport = {held_tuple.sport[7:0], b};
        end else begin
          held_tuple.dport = {held_tuple.dport[7:0], b};
        end
        if (hdr_pos == fthp_pkg::PORT_LAST) begin
          step_on     = 1'b0;
          hdr_pos     = '0;
          parse_phase = fthp_pkg::PH_DONE_FULL;
        end
      end
      // Once the parse has finished, trailing bytes are ignored.
      default: step_on = 1'b0;
    endcase
    if (step_on) hdr_pos = hdr_pos + 5'd1;

    if (lst) begin
      tuple = held_tuple;
      case (parse_phase)
        fthp_pkg::PH_DONE_FULL:  tuple.status = fthp_pkg::ST_FULL;
        fthp_pkg::PH_DONE_OTHER: tuple.status = fthp_pkg::ST_OTHER;
        fthp_pkg::PH_DONE_UNSUP: tuple.status = fthp_pkg::ST_UNSUP;
        default: begin
          // A frame that ends mid-parse reports nothing but the status.
          tuple        = '0;
          tuple.status = fthp_pkg::ST_TRUNC;
        end
      endcase
      expected_tuples.push_back(tuple);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every accepted result is matched against the oldest
  // prediction. Outputs are sampled at the rising edge, before any of the
  // nonblocking updates of that edge take effect.
  // ---------------------------------------------------------------------------
  task automatic report_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input fthp_pkg::out_item_t got);
    fthp_pkg::out_item_t want;
    if (expected_tuples.size() == 0) begin
      $display("%0t ns: result with none expected, expected none actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = expected_tuples.pop_front();
      report_field("src_ip",   want.src_ip,          got.src_ip);
      report_field("dst_ip",   want.dst_ip,          got.dst_ip);
      report_field("sport",    32'(want.sport),      32'(got.sport));
      report_field("dport",    32'(want.dport),      32'(got.dport));
      report_field("protocol", 32'(want.protocol),   32'(got.protocol));
      report_field("status",   32'(want.status),     32'(got.status));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_item);
  end

  // ---------------------------------------------------------------------------
  // Result receiver. Before each result it draws a random stall length, unless it runs
  // steady or a long hold has been requested. Each edge gets at most one assignment
  // to out_stall.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int unsigned wait_cycles;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        wait_cycles    = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        wait_cycles = rx_steady ? 0 : $urandom_range(0, 17);
      end
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && rx_hold_cycles == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender. Valid is only lowered when a gap follows, so a byte that is
  // followed at once by the next keeps valid high without a glitch. Anything
  // that spends time outside this task lowers valid first.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{pkt_byte: b, last_byte: lst};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    parse_byte(b, lst);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // Lowers valid and waits until every predicted tuple has come back. It waits
  // on a clock edge before it checks, so valid is never lowered and raised in one step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tuples.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Frame building. MAC addresses, the VLAN tag control word, the unused IPv4
  // header bytes and any trailing payload are random. Port bytes are only
  // added for TCP and UDP, and the IPv4 header only for an IPv4 ethertype.
  // ---------------------------------------------------------------------------
  task automatic build_frame(input bit with_vlan, input logic [15:0] etype,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, input logic [15:0] sport,
                             input logic [15:0] dport, input int unsigned tail_len);
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    if (with_vlan) begin
      frame_bytes.push_back(fthp_pkg::ETYPE_VLAN[15:8]);
      frame_bytes.push_back(fthp_pkg::ETYPE_VLAN[7:0]);
      repeat (2) frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(etype[15:8]);
    frame_bytes.push_back(etype[7:0]);
    if (etype == fthp_pkg::ETYPE_IPV4) begin
      repeat (9) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(proto);
      repeat (2) frame_bytes.push_back(8'($urandom));
      for (int k = 3; k >= 0; k--) frame_bytes.push_back(src[8*k +: 8]);
      for (int k = 3; k >= 0; k--) frame_bytes.push_back(dst[8*k +: 8]);
      if (proto == fthp_pkg::PROTO_TCP || proto == fthp_pkg::PROTO_UDP) begin
        frame_bytes.push_back(sport[15:8]);
        frame_bytes.push_back(sport[7:0]);
        frame_bytes.push_back(dport[15:8]);
        frame_bytes.push_back(dport[7:0]);
      end
    end
    repeat (tail_len) frame_bytes.push_back(8'($urandom));
  endtask

  // Shortens the frame so that its last byte lands mid-parse.
  task automatic cut_frame(input int unsigned keep);
    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endtask

  // An ethertype that the parser does not follow: IPv6 half the time.
  function automatic logic [15:0] foreign_ethertype();
    logic [15:0] etype;
    if ($urandom_range(0, 1) == 0) return 16'h86DD;
    do etype = 16'($urandom);
    while (etype == fthp_pkg::ETYPE_IPV4 || etype == fthp_pkg::ETYPE_VLAN);
    return etype;
  endfunction

  // A random frame. Nearly half are well-formed up to the ports so that the parse
  // goes deep; the rest end early, use other protocols or ethertypes, or are
  // plain noise.
  task automatic random_frame();
    int unsigned sel;
    logic [7:0]  proto;
    sel   = $urandom_range(0, 99);
    proto = $urandom_range(0, 1) ? fthp_pkg::PROTO_TCP : fthp_pkg::PROTO_UDP;
    if (sel < 45) begin
      build_frame($urandom_range(0, 9) < 3, fthp_pkg::ETYPE_IPV4, proto, $urandom,
                  $urandom, 16'($urandom), 16'($urandom), $urandom_range(0, 6));
    end else if (sel < 60) begin
      do proto = 8'($urandom);
      while (proto == fthp_pkg::PROTO_TCP || proto == fthp_pkg::PROTO_UDP);
      build_frame(1'($urandom_range(0, 1)), fthp_pkg::ETYPE_IPV4, proto, $urandom,
                  $urandom, 16'h0, 16'h0, $urandom_range(0, 6));
    end else if (sel < 70) begin
      build_frame(1'b1,
                  $urandom_range(0, 2) == 0 ? fthp_pkg::ETYPE_VLAN : foreign_ethertype(),
                  proto, 32'h0, 32'h0, 16'h0, 16'h0, $urandom_range(0, 8));
    end else if (sel < 78) begin
      build_frame(1'b0, foreign_ethertype(), proto, 32'h0, 32'h0, 16'h0, 16'h0,
                  $urandom_range(0, 8));
    end else if (sel < 90) begin
      build_frame(1'($urandom_range(0, 1)), fthp_pkg::ETYPE_IPV4, proto, $urandom,
                  $urandom, 16'($urandom), 16'($urandom), 0);
      cut_frame($urandom_range(1, frame_bytes.size() - 1));
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 48)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Frames for each outcome: full tuples at the field extremes, other protocols,
  // IPv6, near-miss and all-ones ethertypes, and the nested VLAN tag.
  task automatic test_status_codes();
    build_frame(1'b0, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_TCP, '1, '1, '1, '1, 0);
    send_frame();
    build_frame(1'b1, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_UDP, '0, '0, '0, '0, 3);
    send_frame();
    build_frame(1'b0, fthp_pkg::ETYPE_IPV4, 8'hFF, 32'hC0A8_0001, 32'h0A00_00FE,
                '0, '0, 0);
    send_frame();
    build_frame(1'b1, fthp_pkg::ETYPE_IPV4, 8'h00, 32'h8000_0001, 32'h7FFF_FFFE,
                '0, '0, 2);
    send_frame();
    build_frame(1'b0, 16'h86DD, fthp_pkg::PROTO_TCP, '0, '0, '0, '0, 0);
    send_frame();
    build_frame(1'b0, 16'h0008, fthp_pkg::PROTO_TCP, '0, '0, '0, '0, 5);
    send_frame();
    build_frame(1'b0, 16'hFFFF, fthp_pkg::PROTO_TCP, '0, '0, '0, '0, 1);
    send_frame();
    build_frame(1'b1, fthp_pkg::ETYPE_VLAN, fthp_pkg::PROTO_TCP, '0, '0, '0, '0, 4);
    send_frame();
    build_frame(1'b1, 16'h86DD, fthp_pkg::PROTO_UDP, '0, '0, '0, '0, 0);
    send_frame();
  endtask

  // Frames that end before the parse is done, at or next to the header boundaries.
  task automatic test_truncation();
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    build_frame(1'b0, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_TCP, '1, '1, '1, '1, 0);
    cut_frame(14);
    send_frame();
    build_frame(1'b1, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_TCP, '1, '1, '1, '1, 0);
    cut_frame(15);
    send_frame();
    build_frame(1'b1, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_UDP, '1, '1, '1, '1, 0);
    cut_frame(18);
    send_frame();
    build_frame(1'b0, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_UDP, '1, '1, '1, '1, 0);
    cut_frame(34);
    send_frame();
    build_frame(1'b0, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_TCP, '1, '1, '1, '1, 0);
    cut_frame(37);
    send_frame();
  endtask

  // Random traffic with changing pacing until about 650 bytes have gone in
  // overall. Now and then the sender pauses until every predicted tuple has
  // come back.
  task automatic test_random_traffic();
    while (bytes_sent < 650) begin
      if ($urandom_range(0, 7) == 0) tx_steady = ~tx_steady;
      if ($urandom_range(0, 7) == 0) rx_steady = ~rx_steady;
      random_frame();
      send_frame();
      if ($urandom_range(0, 11) == 0) wait_for_results();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender streams short
  // frames back to back, so the result stage fills and the input stalls. Then
  // the sender pauses until everything has drained.
  task automatic test_output_hold_off();
    wait_for_results();
    tx_steady      = 1'b1;
    rx_hold_cycles = 400;
    repeat (12) begin
      if ($urandom_range(0, 3) == 0) begin
        build_frame(1'b0, fthp_pkg::ETYPE_IPV4, fthp_pkg::PROTO_UDP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 0);
      end else begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
    end
    tx_steady = 1'b0;
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, then keep the clock running
  // so that any stray result still shows up before the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_status_codes();
    test_truncation();
    test_output_hold_off();
    test_random_traffic();

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far below this.
  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: five_tuple_header_parser_core.f
rtl/core/fthp_pkg.sv
rtl/core/fthp_parser.sv
rtl/core/fthp_out_stage.sv
rtl/core/five_tuple_header_parser_core.sv
rtl/core/fthp_checker.sv
test/tb.sv
